// File: src/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define SAWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent holds, consequent must hold in the same cycle
`define SAWC_ASSERT_IMP(label, ante, cons, msg) \
    `SAWC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: src/sawc_pkg.sv
// Package for the set-associative write-back cache: sizes, codes, types.
// No dependencies.
`default_nettype none
package sawc_pkg;
    localparam int SETS           = 128;
    localparam int WAYS           = 4;
    localparam int WORDS_PER_LINE = 8;
    localparam int MEM_WORDS      = 65536;
    localparam int AGE_BITS       = 16;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int OFF_W    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = ADDR_W - OFF_W - SET_W;
    localparam int MEM_W    = $clog2(MEM_WORDS);
    localparam int LW_IDX_W = SET_W + WAY_W + OFF_W;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRELOAD = 2'd2;

    localparam logic [1:0] ST_INVALID  = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_MODIFIED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Back end requests to the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]    tag;
        logic [WAYS-1:0][1:0]          st;
        logic [WAYS-1:0][AGE_BITS-1:0] age;
    } meta_row_t;
endpackage
`default_nettype wire

// File: src/set_assoc_writeback_cache.sv
// Top level of the 4-way set-associative write-back cache.
// Depends on sawc_pkg, sawc_front and sawc_back.
//
// channel  handshake            payload
// in       in_valid/in_ready    cmd, address, write_data
// out      out_valid/out_ready  read_data, hit, wrote_back
//
// Reset: backing memory is cleared word by word; in_ready stays low.
// Preload and unused commands: finished in S_IDLE as the back end takes them.
// Write hit: S_META only; read hit: S_META then S_HITRD (tag read, then data read).
// Miss: S_META, then S_FILL_RD and S_FILL_WR per word for the line fill and write-back.
// A two-entry queue takes beats while a result waits on out_ready.
`default_nettype none
module set_assoc_writeback_cache
    import sawc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [DATA_W-1:0] write_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      read_data,
    output logic                   hit,
    output logic                   wrote_back
);
    head_t     head;
    back_ctl_t ctl;

    sawc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .address    (address),
        .write_data (write_data),
        .ctl        (ctl),
        .head       (head)
    );

    sawc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .hit        (hit),
        .wrote_back (wrote_back)
    );
endmodule
`default_nettype wire

// File: src/sawc_front.sv
// Front end: accepts input beats into a two-entry queue.
// Depends on sawc_pkg.
`default_nettype none
module sawc_front
    import sawc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [DATA_W-1:0] write_data,
    input  wire back_ctl_t         ctl,
    output head_t                  head
);
    item_t      q_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    // Hold off beats while full or while memory is being cleared
    assign in_ready = (cnt_reg != 2'd2) && !ctl.clearing;
    assign push     = in_valid && in_ready;

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= '{cmd: cmd, address: address, write_data: write_data};
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (ctl.pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, ctl.pop};
        end
    end
endmodule
`default_nettype wire

// File: src/sawc_back.sv
// Back end: tag lookup, aging, line fill and write-back, backing memory.
// Depends on sawc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sawc_back
    import sawc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire head_t        head,
    output back_ctl_t         ctl,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic              hit,
    output logic              wrote_back
);
    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_META    = 6'b000100,
        S_HITRD   = 6'b001000,
        S_FILL_RD = 6'b010000,
        S_FILL_WR = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    meta_row_t         meta_mem [SETS];
    logic [DATA_W-1:0] lw_mem   [SETS*WAYS*WORDS_PER_LINE];
    logic [DATA_W-1:0] bm_mem   [MEM_WORDS];
    logic [SETS-1:0]   set_vld_reg;

    meta_row_t         meta_q;
    logic              meta_vld_q;
    logic [DATA_W-1:0] lw_q, bm_q;

    // Item and miss context
    item_t             item_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [TAG_W-1:0]  old_tag_reg;
    logic              old_mod_reg;
    logic [OFF_W-1:0]  k_reg;
    logic [MEM_W-1:0]  clr_reg;

    // Result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_reg;
    logic              hit_reg, wb_reg;

    logic              start;
    logic [OFF_W-1:0]  off;
    logic [SET_W-1:0]  set_i, head_set;
    logic [TAG_W-1:0]  tag_i;

    meta_row_t         row_in, row_new;
    logic              found;
    logic [WAY_W-1:0]  found_way, victim;
    logic [AGE_BITS-1:0] best;

    logic              meta_we, lw_we, bm_we;
    logic [LW_IDX_W-1:0] lw_waddr, lw_raddr;
    logic [DATA_W-1:0] lw_wdata, bm_wdata;
    logic [MEM_W-1:0]  bm_waddr, bm_raddr;

    assign off      = item_reg.address[OFF_W-1:0];
    assign set_i    = item_reg.address[OFF_W +: SET_W];
    assign tag_i    = item_reg.address[ADDR_W-1 -: TAG_W];
    assign head_set = head.item.address[OFF_W +: SET_W];

    assign start        = (state_reg == S_IDLE) && head.valid && !out_valid_reg;
    assign ctl.pop      = start;
    assign ctl.clearing = (state_reg == S_CLEAR);

    assign out_valid  = out_valid_reg;
    assign read_data  = rd_reg;
    assign hit        = hit_reg;
    assign wrote_back = wb_reg;

    // Lookup: age the set, find the hit way or the victim
    always_comb
    begin
        row_in    = meta_vld_q ? meta_q : '0;
        row_new   = row_in;
        found     = 1'b0;
        found_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_in.st[w] != ST_INVALID && row_in.tag[w] == tag_i)
            begin
                row_new.age[w] = '0;
                found          = 1'b1;
                found_way      = WAY_W'(w);
            end
            else if (row_in.age[w] != AGE_MAX)
            begin
                row_new.age[w] = row_in.age[w] + 1'b1;
            end
        end
        victim = '0;
        best   = row_new.age[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (row_new.age[w] > best)
            begin
                best   = row_new.age[w];
                victim = WAY_W'(w);
            end
        end
        if (found)
        begin
            if (item_reg.cmd == CMD_WRITE)
            begin
                row_new.st[found_way] = ST_MODIFIED;
            end
        end
        else
        begin
            row_new.tag[victim] = tag_i;
            row_new.st[victim]  = ST_VALID;
            row_new.age[victim] = '0;
        end
    end

    // Memory port selection
    always_comb
    begin
        meta_we  = (state_reg == S_META);
        lw_we    = 1'b0;
        lw_waddr = {set_i, way_reg, k_reg};
        lw_wdata = bm_q;
        lw_raddr = {set_i, way_reg, k_reg};
        bm_we    = 1'b0;
        bm_waddr = {old_tag_reg, set_i, k_reg};
        bm_wdata = lw_q;
        bm_raddr = {tag_i, set_i, k_reg};
        case (state_reg)
            S_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                bm_wdata = '0;
            end
            S_IDLE:
            begin
                if (start && head.item.cmd == CMD_PRELOAD)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = head.item.address;
                    bm_wdata = head.item.write_data;
                end
            end
            S_META:
            begin
                if (found)
                begin
                    lw_raddr = {set_i, found_way, off};
                    lw_waddr = {set_i, found_way, off};
                    lw_wdata = item_reg.write_data;
                    lw_we    = (item_reg.cmd == CMD_WRITE);
                end
                else if (item_reg.cmd == CMD_WRITE)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = item_reg.address;
                    bm_wdata = item_reg.write_data;
                end
            end
            S_FILL_WR:
            begin
                lw_we = 1'b1;
                bm_we = old_mod_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Metadata memory, registered read
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[set_i] <= row_new;
        end
        meta_q <= meta_mem[head_set];
    end

    // Line word memory, registered read
    always_ff @(posedge clk)
    begin
        if (lw_we)
        begin
            lw_mem[lw_waddr] <= lw_wdata;
        end
        lw_q <= lw_mem[lw_raddr];
    end

    // Backing memory, registered read
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_q <= bm_mem[bm_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   state_next = (clr_reg == {MEM_W{1'b1}}) ? S_IDLE : S_CLEAR;
            S_IDLE:
            begin
                if (start && (head.item.cmd == CMD_READ || head.item.cmd == CMD_WRITE))
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                if (!found)
                begin
                    state_next = S_FILL_RD;
                end
                else if (item_reg.cmd == CMD_READ)
                begin
                    state_next = S_HITRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HITRD:   state_next = S_IDLE;
            S_FILL_RD: state_next = S_FILL_WR;
            S_FILL_WR: state_next = (k_reg == {OFF_W{1'b1}}) ? S_IDLE : S_FILL_RD;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            set_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            meta_vld_q    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            meta_vld_q <= set_vld_reg[head_set];
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (meta_we)
            begin
                set_vld_reg[set_i] <= 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE)
            begin
                k_reg <= '0;
            end
            else if (state_reg == S_FILL_WR)
            begin
                k_reg <= k_reg + 1'b1;
            end
            // Raise the result beat at the end of each item
            if (start && head.item.cmd != CMD_READ && head.item.cmd != CMD_WRITE)
            begin
                out_valid_reg <= 1'b1;
            end
            if ((state_reg == S_META && found && item_reg.cmd == CMD_WRITE)
                || state_reg == S_HITRD
                || (state_reg == S_FILL_WR && k_reg == {OFF_W{1'b1}}))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload and miss context
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= head.item;
            rd_reg   <= '0;
            hit_reg  <= 1'b0;
            wb_reg   <= 1'b0;
        end
        if (state_reg == S_META)
        begin
            hit_reg     <= found;
            way_reg     <= victim;
            old_tag_reg <= row_in.tag[victim];
            old_mod_reg <= (row_in.st[victim] == ST_MODIFIED);
            wb_reg      <= !found && (row_in.st[victim] == ST_MODIFIED);
        end
        if (state_reg == S_HITRD)
        begin
            rd_reg <= lw_q;
        end
        if (state_reg == S_FILL_WR && k_reg == off && item_reg.cmd == CMD_READ)
        begin
            rd_reg <= bm_q;
        end
    end

    `SAWC_ASSERT_IMP(a_wb_not_hit, out_valid_reg && wb_reg, !hit_reg,
        "write-back reported on a hit")
    `SAWC_ASSERT_IMP(a_clear_quiet, state_reg == S_CLEAR, !out_valid_reg && !ctl.pop,
        "activity during memory clear")
    `SAWC_ASSERT_IMP(a_fill_idle_k, state_reg == S_FILL_RD && $past(state_reg) == S_META,
        k_reg == '0, "fill did not start at word zero")
endmodule
`default_nettype wire
